[hw/rtl/acw_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the AIMD congestion window engine.
// Depends on nothing; every other file of the block but acw_checker imports it.
package acw_pkg;

    localparam int COUNT_BITS = 16;
    localparam int TIME_BITS  = 48;

    localparam int DIV_STEPS     = 32;
    localparam int DIVIDEND_BITS = 32;
    localparam int DIVISOR_BITS  = 16;
    localparam int STEP_BITS     = $clog2(DIV_STEPS);

    localparam logic [16:0] Q16_ONE = 17'h10000;
    localparam logic [24:0] Q24_ONE = 25'h1000000;

    localparam logic [15:0] RST_INITIAL_WINDOW    = 16'd10;
    localparam logic [15:0] RST_INITIAL_THRESHOLD = 16'd65535;
    localparam logic [15:0] RST_MAX_WINDOW        = 16'd65535;
    localparam logic [15:0] RST_MIN_WINDOW        = 16'd2;
    localparam logic [16:0] RST_LOSS_ALPHA        = 17'd6554;
    localparam logic [16:0] RST_LOSS_TOLERANCE    = 17'd6554;
    localparam logic [16:0] RST_BETA              = 17'd45875;
    localparam logic [31:0] RST_MIN_GUARD         = 32'd200000;

    typedef enum logic [2:0] {
        KIND_SENT    = 3'd0,
        KIND_ACKED   = 3'd1,
        KIND_LOST    = 3'd2,
        KIND_EXPIRED = 3'd3,
        KIND_RTT     = 3'd4,
        KIND_RESTART = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        CFG_INITIAL_WINDOW    = 3'd0,
        CFG_INITIAL_THRESHOLD = 3'd1,
        CFG_MAX_WINDOW        = 3'd2,
        CFG_MIN_WINDOW        = 3'd3,
        CFG_LOSS_ALPHA        = 3'd4,
        CFG_LOSS_TOLERANCE    = 3'd5,
        CFG_BETA              = 3'd6,
        CFG_MIN_GUARD         = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_MUL,
        ST_AVG_UPD,
        ST_LOSS_CHK,
        ST_CUT_MUL,
        ST_CUT_APPLY,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] initial_window;
        logic [15:0] initial_threshold;
        logic [15:0] max_window;
        logic [15:0] min_window;
        logic [16:0] loss_alpha;
        logic [16:0] loss_tolerance;
        logic [16:0] beta;
        logic [31:0] min_guard;
    } cfg_t;

    typedef struct packed {
        logic                     start;
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [DIVISOR_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic [DIVIDEND_BITS-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic        window_cut;
        logic        slow_start;
        logic [31:0] pacing_us;
        logic [15:0] threshold;
        logic [15:0] outstanding;
        logic [15:0] window;
    } res_t;

    function automatic logic [16:0] q16_clamp(input logic [16:0] v);
        q16_clamp = (v > Q16_ONE) ? Q16_ONE : v;
    endfunction

endpackage

[hw/rtl/aimd_congestion_window.sv]
`timescale 1ns / 1ps
// Top level of the AIMD congestion window engine: configuration registers,
// stream ports and the result register. Depends on acw_pkg, acw_engine and acw_divider.
//
// One event item is taken at a time, and s_axis_tready stays low until its result has
// been moved into the output register. Sent, restart and unused kinds, and an RTT update
// with a zero window or a zero RTT, go straight to the result; an ack in slow start passes
// the average multiply and update; a loss or expiry also the loss check, and the cut
// multiply and apply when it cuts the window; an RTT update and an ack in congestion
// avoidance wait for the 32-step serial divider that forms the pacing quotient and the
// window reciprocal. The next item can be accepted once the engine is back in idle, which
// it enters as its result is registered. A finished result waits in the output register
// while the next item is accepted; if it is still stalled there when the following result
// is ready, the engine holds and the input stays not ready until m_axis_tready is seen.
module aimd_congestion_window (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // now_us[47:0], srtt_us[79:48]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // window, outstanding, threshold, pacing_us,
                                        // slow_start[80], window_cut[81], zero pad
);
    import acw_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     m_valid_reg, m_valid_next;
    res_t     m_res_reg;
    res_t     res;
    logic     idle;
    logic     res_valid;
    logic     res_ready;
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_INITIAL_WINDOW:    cfg_next.initial_window    = cfg_wdata[15:0];
                CFG_INITIAL_THRESHOLD: cfg_next.initial_threshold = cfg_wdata[15:0];
                CFG_MAX_WINDOW:        cfg_next.max_window        = cfg_wdata[15:0];
                CFG_MIN_WINDOW:        cfg_next.min_window        = cfg_wdata[15:0];
                CFG_LOSS_ALPHA:        cfg_next.loss_alpha        = cfg_wdata[16:0];
                CFG_LOSS_TOLERANCE:    cfg_next.loss_tolerance    = cfg_wdata[16:0];
                CFG_BETA:              cfg_next.beta              = cfg_wdata[16:0];
                CFG_MIN_GUARD:         cfg_next.min_guard         = cfg_wdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_window    <= RST_INITIAL_WINDOW;
            cfg_reg.initial_threshold <= RST_INITIAL_THRESHOLD;
            cfg_reg.max_window        <= RST_MAX_WINDOW;
            cfg_reg.min_window        <= RST_MIN_WINDOW;
            cfg_reg.loss_alpha        <= RST_LOSS_ALPHA;
            cfg_reg.loss_tolerance    <= RST_LOSS_TOLERANCE;
            cfg_reg.beta              <= RST_BETA;
            cfg_reg.min_guard         <= RST_MIN_GUARD;
            m_valid_reg               <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    acw_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (s_axis_tvalid && idle),
        .kind      (kind_t'(s_axis_tuser)),
        .now_us    (s_axis_tdata[47:0]),
        .srtt_us   (s_axis_tdata[79:48]),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    acw_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_axis_tready = idle;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, m_res_reg};

endmodule

[hw/rtl/acw_divider.sv]
`timescale 1ns / 1ps
// Serial restoring divider, one quotient bit per clock.
// Depends on acw_pkg for widths and the request and response structs.
module acw_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  acw_pkg::div_req_t req,
    output acw_pkg::div_rsp_t rsp
);
    import acw_pkg::*;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[DIVISOR_BITS-1:0];
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_BITS-1:0];
                quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_BITS'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[hw/rtl/acw_engine.sv]
`timescale 1ns / 1ps
// Event sequencer and window state: one multiplier and the shared serial divider.
// Depends on acw_pkg; drives an acw_divider through the request and response structs.
module acw_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  acw_pkg::cfg_t     cfg,
    input  logic              start,
    input  acw_pkg::kind_t    kind,
    input  logic [47:0]       now_us,
    input  logic [31:0]       srtt_us,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_ready,
    output acw_pkg::res_t     res,
    output acw_pkg::div_req_t div_req,
    input  acw_pkg::div_rsp_t div_rsp
);
    import acw_pkg::*;

    localparam int CMP_BITS = TIME_BITS + 32;
    localparam int SAT_BITS = COUNT_BITS + 16;

    state_t                state_reg, state_next;
    kind_t                 kind_reg, kind_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [15:0]           window_reg, window_next;
    logic [15:0]           threshold_reg, threshold_next;
    logic [COUNT_BITS-1:0] flight_reg, flight_next;
    logic [31:0]           pacing_reg, pacing_next;
    logic [24:0]           frac_reg, frac_next;
    logic [31:0]           rtt_reg, rtt_next;
    logic [16:0]           avg_reg, avg_next;
    logic [TIME_BITS-1:0]  last_cut_reg, last_cut_next;
    logic                  cut_seen_reg, cut_seen_next;
    logic                  cut_flag_reg, cut_flag_next;
    logic [33:0]           prod_reg;

    logic [16:0]           alpha_c;
    logic [16:0]           one_minus_alpha;
    logic [16:0]           mul_a;
    logic [16:0]           mul_b;
    logic [34:0]           loss_sum;
    logic [18:0]           loss_raw;
    logic [TIME_BITS-1:0]  since;
    logic [31:0]           guard;
    logic                  too_soon;
    logic [17:0]           cut_val;
    logic [15:0]           cut_floor;
    logic [25:0]           frac_sum;
    logic [15:0]           window_up;
    logic [COUNT_BITS-1:0] flight_up;
    logic [COUNT_BITS-1:0] flight_down;
    logic [SAT_BITS-1:0]   flight_wide;

    always_comb
    begin
        alpha_c         = q16_clamp(cfg.loss_alpha);
        one_minus_alpha = Q16_ONE - alpha_c;
        if (state_reg == ST_CUT_MUL)
        begin
            mul_a = {1'b0, window_reg};
            mul_b = q16_clamp(cfg.beta);
        end
        else
        begin
            mul_a = avg_reg;
            mul_b = one_minus_alpha;
        end
        loss_sum    = {1'b0, prod_reg} + {2'b0, alpha_c, 16'b0};
        loss_raw    = loss_sum[34:16];
        since       = now_reg - last_cut_reg;
        guard       = (rtt_reg != '0) ? rtt_reg : cfg.min_guard;
        too_soon    = cut_seen_reg && (CMP_BITS'(since) < CMP_BITS'(guard));
        cut_val     = prod_reg[33:16];
        cut_floor   = (cut_val < {2'b0, cfg.min_window}) ? cfg.min_window : cut_val[15:0];
        frac_sum    = {1'b0, frac_reg} + {1'b0, div_rsp.quotient[24:0]};
        window_up   = (window_reg < cfg.max_window) ? window_reg + 16'd1 : window_reg;
        flight_up   = (flight_reg == '1) ? flight_reg : flight_reg + 1'b1;
        flight_down = (flight_reg == '0) ? flight_reg : flight_reg - 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        now_next       = now_reg;
        window_next    = window_reg;
        threshold_next = threshold_reg;
        flight_next    = flight_reg;
        pacing_next    = pacing_reg;
        frac_next      = frac_reg;
        rtt_next       = rtt_reg;
        avg_next       = avg_reg;
        last_cut_next  = last_cut_reg;
        cut_seen_next  = cut_seen_reg;
        cut_flag_next  = cut_flag_reg;
        div_req.start    = 1'b0;
        div_req.dividend = srtt_us;
        div_req.divisor  = window_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next     = kind;
                    now_next      = TIME_BITS'(now_us);
                    cut_flag_next = 1'b0;
                    state_next    = ST_DONE;
                    case (kind)
                        KIND_SENT:
                        begin
                            flight_next = flight_up;
                        end
                        KIND_ACKED, KIND_LOST, KIND_EXPIRED:
                        begin
                            flight_next = flight_down;
                            state_next  = ST_AVG_MUL;
                        end
                        KIND_RTT:
                        begin
                            rtt_next = srtt_us;
                            if (window_reg == '0 || srtt_us == '0)
                            begin
                                pacing_next = '0;
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV_WAIT;
                            end
                        end
                        KIND_RESTART:
                        begin
                            window_next    = cfg.initial_window;
                            threshold_next = cfg.initial_threshold;
                            flight_next    = '0;
                            pacing_next    = '0;
                            frac_next      = '0;
                            rtt_next       = '0;
                            avg_next       = '0;
                            last_cut_next  = '0;
                            cut_seen_next  = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_AVG_MUL:
            begin
                state_next = ST_AVG_UPD;
            end
            ST_AVG_UPD:
            begin
                if (kind_reg == KIND_ACKED)
                begin
                    avg_next = prod_reg[32:16];
                    if (window_reg < threshold_reg)
                    begin
                        window_next = window_up;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIVIDEND_BITS'(Q24_ONE);
                        div_req.divisor  = (window_reg == '0) ? 16'd1 : window_reg;
                        state_next       = ST_DIV_WAIT;
                    end
                end
                else
                begin
                    avg_next   = (loss_raw > {2'b0, Q16_ONE}) ? Q16_ONE : loss_raw[16:0];
                    state_next = ST_LOSS_CHK;
                end
            end
            ST_LOSS_CHK:
            begin
                if (avg_reg < cfg.loss_tolerance || too_soon)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    last_cut_next = now_reg;
                    cut_seen_next = 1'b1;
                    state_next    = ST_CUT_MUL;
                end
            end
            ST_CUT_MUL:
            begin
                state_next = ST_CUT_APPLY;
            end
            ST_CUT_APPLY:
            begin
                threshold_next = cut_floor;
                window_next    = cut_floor;
                frac_next      = '0;
                cut_flag_next  = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (kind_reg == KIND_ACKED)
                    begin
                        if (frac_sum >= {1'b0, Q24_ONE})
                        begin
                            window_next = window_up;
                            frac_next   = frac_sum[24:0] - Q24_ONE;
                        end
                        else
                        begin
                            frac_next = frac_sum[24:0];
                        end
                    end
                    else
                    begin
                        pacing_next = div_rsp.quotient;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= RST_INITIAL_WINDOW;
            threshold_reg <= RST_INITIAL_THRESHOLD;
            flight_reg    <= '0;
            pacing_reg    <= '0;
            frac_reg      <= '0;
            rtt_reg       <= '0;
            avg_reg       <= '0;
            last_cut_reg  <= '0;
            cut_seen_reg  <= 1'b0;
            cut_flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            threshold_reg <= threshold_next;
            flight_reg    <= flight_next;
            pacing_reg    <= pacing_next;
            frac_reg      <= frac_next;
            rtt_reg       <= rtt_next;
            avg_reg       <= avg_next;
            last_cut_reg  <= last_cut_next;
            cut_seen_reg  <= cut_seen_next;
            cut_flag_reg  <= cut_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        now_reg  <= now_next;
        prod_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        flight_wide     = SAT_BITS'(flight_reg);
        idle            = (state_reg == ST_IDLE);
        res_valid       = (state_reg == ST_DONE);
        res.window      = window_reg;
        res.outstanding = (flight_wide > SAT_BITS'(16'hFFFF)) ? 16'hFFFF : flight_wide[15:0];
        res.threshold   = threshold_reg;
        res.pacing_us   = pacing_reg;
        res.slow_start  = (window_reg < threshold_reg);
        res.window_cut  = cut_flag_reg;
    end

endmodule

[hw/rtl/acw_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the AIMD congestion window engine, bound to its top level.
// Depends only on the ports of aimd_congestion_window.
module acw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);

    logic [15:0] out_window;
    logic [15:0] out_threshold;
    logic        out_slow_start;
    logic        out_window_cut;

    assign out_window     = m_axis_tdata[15:0];
    assign out_threshold  = m_axis_tdata[47:32];
    assign out_slow_start = m_axis_tdata[80];
    assign out_window_cut = m_axis_tdata[81];

    // Only one item is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("acw: item accepted while previous item still in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("acw: stalled result changed or dropped");

    // A decrease sets the window and the threshold to the same value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_window_cut |-> out_window == out_threshold && !out_slow_start)
        else $error("acw: cut result with window differing from threshold");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_slow_start == (out_window < out_threshold))
        else $error("acw: slow start flag disagrees with window and threshold");

endmodule

bind aimd_congestion_window acw_checker u_acw_checker (.*);

[dv/tb_aimd_congestion_window.sv]
`timescale 1ns / 1ps
// Self-checking testbench for aimd_congestion_window: directed and random stream
// traffic and register settings, each result checked against an in-bench window model.
// Depends on acw_pkg and the RTL of the block; reads no files.
module tb_aimd_congestion_window;

    import acw_pkg::*;

    localparam logic [2:0]  KIND_SPARE_LO = 3'd6;
    localparam logic [2:0]  KIND_SPARE_HI = 3'd7;
    localparam longint unsigned ONE_Q16 = 64'd65536;
    localparam longint unsigned ONE_Q24 = 64'd16777216;

    typedef struct {
        logic [15:0] init_window;
        logic [15:0] init_threshold;
        logic [15:0] max_window;
        logic [15:0] min_window;
        logic [16:0] alpha;
        logic [16:0] tolerance;
        logic [16:0] beta;
        logic [31:0] min_guard;
    } window_cfg_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;

    window_cfg_t cfg_copy;
    logic [15:0] win_model;
    logic [15:0] thr_model;
    logic [15:0] flight_model;
    logic [31:0] pacing_model;
    logic [31:0] rtt_model;
    logic [24:0] frac_model;
    logic [16:0] avg_model;
    logic [47:0] last_cut_model;
    logic        cut_seen_model;

    res_t        pending_reports[$];
    logic [47:0] clock_us;
    bit          idling_on;
    int          sink_hold = 0;
    int          results_taken = 0;
    int          holds_drawn = 0;
    int          error_count = 0;
    int          events_sent;
    int          reports_checked = 0;
    int          cuts_observed = 0;
    int          settings_used;

    aimd_congestion_window u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint unsigned sat_q16(input longint unsigned v);
        sat_q16 = (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    function automatic void restart_window_model();
        win_model      = cfg_copy.init_window;
        thr_model      = cfg_copy.init_threshold;
        flight_model   = '0;
        pacing_model   = '0;
        rtt_model      = '0;
        frac_model     = '0;
        avg_model      = '0;
        last_cut_model = '0;
        cut_seen_model = 1'b0;
    endfunction

    function automatic bit apply_loss(input logic [47:0] now_us);
        longint unsigned a;
        longint unsigned guard;
        longint unsigned cut_value;
        logic [47:0]     since;
        a = sat_q16(longint'(cfg_copy.alpha));
        if (flight_model != 0)
            flight_model = flight_model - 16'd1;
        avg_model = 17'(sat_q16((longint'(avg_model) * (ONE_Q16 - a) + (a << 16)) >> 16));
        if (avg_model < cfg_copy.tolerance)
            return 1'b0;
        guard = (rtt_model != 0) ? longint'(rtt_model) : longint'(cfg_copy.min_guard);
        since = now_us - last_cut_model;
        if (cut_seen_model && longint'(since) < guard)
            return 1'b0;
        last_cut_model = now_us;
        cut_seen_model = 1'b1;
        cut_value = (longint'(win_model) * sat_q16(longint'(cfg_copy.beta))) >> 16;
        if (cut_value < longint'(cfg_copy.min_window))
            cut_value = longint'(cfg_copy.min_window);
        thr_model  = cut_value[15:0];
        win_model  = thr_model;
        frac_model = '0;
        return 1'b1;
    endfunction

    function automatic void apply_ack();
        longint unsigned a;
        longint unsigned divisor;
        longint unsigned frac;
        a = sat_q16(longint'(cfg_copy.alpha));
        if (flight_model != 0)
            flight_model = flight_model - 16'd1;
        avg_model = 17'((longint'(avg_model) * (ONE_Q16 - a)) >> 16);
        if (win_model < thr_model)
        begin
            if (win_model < cfg_copy.max_window)
                win_model = win_model + 16'd1;
        end
        else
        begin
            divisor = (win_model != 0) ? longint'(win_model) : 64'd1;
            frac = longint'(frac_model) + ONE_Q24 / divisor;
            if (frac >= ONE_Q24)
            begin
                if (win_model < cfg_copy.max_window)
                    win_model = win_model + 16'd1;
                frac = frac - ONE_Q24;
            end
            frac_model = 25'(frac);
        end
    endfunction

    function automatic res_t advance_window_model(input logic [2:0] kind,
                                                  input logic [47:0] now_us,
                                                  input logic [31:0] srtt_us);
        res_t report;
        bit   cut;
        cut = 1'b0;
        case (kind)
            KIND_SENT:
                if (flight_model != 16'hFFFF)
                    flight_model = flight_model + 16'd1;
            KIND_ACKED:
                apply_ack();
            KIND_LOST, KIND_EXPIRED:
                cut = apply_loss(now_us);
            KIND_RTT:
            begin
                rtt_model    = srtt_us;
                pacing_model = (win_model != 0 && srtt_us != 0) ? srtt_us / win_model : '0;
            end
            KIND_RESTART:
                restart_window_model();
            default:
                ;
        endcase
        report.window      = win_model;
        report.outstanding = flight_model;
        report.threshold   = thr_model;
        report.pacing_us   = pacing_model;
        report.slow_start  = (win_model < thr_model);
        report.window_cut  = cut;
        return report;
    endfunction

    task automatic set_register(input cfg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_INITIAL_WINDOW:    cfg_copy.init_window    = value[15:0];
            CFG_INITIAL_THRESHOLD: cfg_copy.init_threshold = value[15:0];
            CFG_MAX_WINDOW:        cfg_copy.max_window     = value[15:0];
            CFG_MIN_WINDOW:        cfg_copy.min_window     = value[15:0];
            CFG_LOSS_ALPHA:        cfg_copy.alpha          = value[16:0];
            CFG_LOSS_TOLERANCE:    cfg_copy.tolerance      = value[16:0];
            CFG_BETA:              cfg_copy.beta           = value[16:0];
            CFG_MIN_GUARD:         cfg_copy.min_guard      = value;
            default:               ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_event(input logic [2:0] kind, input logic [47:0] now_us,
                              input logic [31:0] srtt_us);
        int gap;
        gap = idling_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {srtt_us, now_us};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_reports.push_back(advance_window_model(kind, now_us, srtt_us));
        events_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic check_field(input string name, input longint unsigned expected,
                               input longint unsigned actual);
        if (expected != actual)
        begin
            $display("%0t mismatch on %s: expected %0d, actual %0d",
                     $realtime, name, expected, actual);
            error_count++;
        end
    endtask

    always @(negedge clk)
    begin
        if (holds_drawn != results_taken)
        begin
            holds_drawn = results_taken;
            sink_hold   = idling_on ? $urandom_range(0, 9) : 0;
        end
        if (sink_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        res_t actual;
        res_t expected;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            actual = res_t'(m_axis_tdata[81:0]);
            results_taken++;
            if (actual.window_cut)
                cuts_observed++;
            if (pending_reports.size() == 0)
            begin
                $display("%0t unexpected item on the result stream: %h",
                         $realtime, m_axis_tdata);
                error_count++;
            end
            else
            begin
                expected = pending_reports.pop_front();
                reports_checked++;
                check_field("window", expected.window, actual.window);
                check_field("outstanding", expected.outstanding, actual.outstanding);
                check_field("threshold", expected.threshold, actual.threshold);
                check_field("pacing_us", expected.pacing_us, actual.pacing_us);
                check_field("slow_start", expected.slow_start, actual.slow_start);
                check_field("window_cut", expected.window_cut, actual.window_cut);
            end
        end
    end

    task automatic test_event_kinds();
        send_event(KIND_ACKED, 48'd0, 32'd0);
        send_event(KIND_LOST, 48'd0, 32'd0);
        send_event(KIND_SENT, 48'd1, 32'd0);
        send_event(KIND_SENT, 48'd2, 32'd0);
        send_event(KIND_ACKED, 48'd3, 32'd0);
        send_event(KIND_RTT, 48'd4, 32'd0);
        send_event(KIND_RTT, 48'd5, 32'hFFFF_FFFF);
        send_event(KIND_EXPIRED, 48'hFFFF_FFFF_FFFF, 32'd0);
        send_event(KIND_SPARE_LO, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_event(KIND_SPARE_HI, 48'd0, 32'd0);
        send_event(KIND_RESTART, 48'd0, 32'd0);
        wait_drained();
    endtask

    task automatic test_cut_coalescing();
        send_event(KIND_LOST, 48'hFFFF_FFFF_FFF0, 32'd0);
        send_event(KIND_LOST, 48'd100, 32'd0);
        send_event(KIND_LOST, 48'd199984, 32'd0);
        send_event(KIND_RTT, 48'd199984, 32'd1000);
        send_event(KIND_EXPIRED, 48'd200983, 32'd0);
        send_event(KIND_LOST, 48'd200984, 32'd0);
        send_event(KIND_RESTART, 48'd0, 32'd0);
        wait_drained();
    endtask

    task automatic test_flight_saturation();
        idling_on = 1'b0;
        send_event(KIND_RESTART, 48'd0, 32'd0);
        repeat (6) send_event(KIND_SENT, 48'd0, 32'd0);
        repeat (9) send_event(KIND_ACKED, 48'd0, 32'd0);
        send_event(KIND_LOST, 48'd0, 32'd0);
        send_event(KIND_SENT, 48'd0, 32'd0);
        send_event(KIND_RESTART, 48'd0, 32'd0);
        wait_drained();
        idling_on = 1'b1;
    endtask

    task automatic random_event();
        int          pick;
        logic [2:0]  kind;
        logic [31:0] srtt;
        pick = $urandom_range(0, 99);
        if (pick < 33)
            kind = KIND_SENT;
        else if (pick < 66)
            kind = KIND_ACKED;
        else if (pick < 76)
            kind = KIND_LOST;
        else if (pick < 82)
            kind = KIND_EXPIRED;
        else if (pick < 90)
            kind = KIND_RTT;
        else if (pick < 92)
            kind = KIND_RESTART;
        else if (pick < 93)
            kind = KIND_SPARE_LO;
        else if (pick < 94)
            kind = KIND_SPARE_HI;
        else
            kind = KIND_ACKED;
        if ($urandom_range(0, 19) == 0)
            clock_us = {16'($urandom), 32'($urandom)};
        else
            clock_us = clock_us + 48'($urandom_range(0, 4000));
        case ($urandom_range(0, 9))
            0:       srtt = $urandom;
            1:       srtt = '0;
            default: srtt = $urandom_range(1, 6000);
        endcase
        send_event(kind, clock_us, srtt);
    endtask

    task automatic test_random_traffic(input int count);
        send_event(KIND_RESTART, clock_us, 32'd0);
        repeat (count) random_event();
        wait_drained();
        settings_used++;
    endtask

    task automatic test_register_extremes();
        set_register(CFG_INITIAL_WINDOW, 32'd1);
        set_register(CFG_INITIAL_THRESHOLD, 32'd1);
        set_register(CFG_MAX_WINDOW, 32'd1);
        set_register(CFG_MIN_WINDOW, 32'd1);
        set_register(CFG_LOSS_ALPHA, 32'd65536);
        set_register(CFG_LOSS_TOLERANCE, 32'd0);
        set_register(CFG_BETA, 32'd0);
        set_register(CFG_MIN_GUARD, 32'd0);
        test_random_traffic(150);

        set_register(CFG_INITIAL_WINDOW, 32'hFFFF_0000);
        set_register(CFG_INITIAL_THRESHOLD, 32'hFFFF_0000);
        set_register(CFG_MAX_WINDOW, 32'h0000_FFFF);
        set_register(CFG_MIN_WINDOW, 32'h0000_FFFF);
        set_register(CFG_LOSS_ALPHA, 32'h0001_FFFF);
        set_register(CFG_LOSS_TOLERANCE, 32'h0001_FFFF);
        set_register(CFG_BETA, 32'h0001_FFFF);
        set_register(CFG_MIN_GUARD, 32'hFFFF_FFFF);
        send_event(KIND_RESTART, 48'd0, 32'd0);
        send_event(KIND_RTT, 48'd1, 32'd5);
        send_event(KIND_ACKED, 48'd2, 32'd0);
        send_event(KIND_LOST, 48'd3, 32'd0);
        test_random_traffic(150);

        set_register(CFG_LOSS_TOLERANCE, 32'd65536);
        test_random_traffic(60);
    endtask

    task automatic test_random_settings(input int count);
        set_register(CFG_INITIAL_WINDOW, {16'($urandom), 16'($urandom_range(1, 300))});
        set_register(CFG_INITIAL_THRESHOLD,
                     {16'($urandom), ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                                : 16'($urandom_range(1, 600))});
        set_register(CFG_MAX_WINDOW,
                     {16'($urandom), ($urandom_range(0, 1) == 0) ? 16'hFFFF
                                                                : 16'($urandom_range(1, 1000))});
        set_register(CFG_MIN_WINDOW, {16'($urandom), 16'($urandom_range(1, 20))});
        set_register(CFG_LOSS_ALPHA, {15'($urandom), 17'($urandom_range(0, 65536))});
        set_register(CFG_LOSS_TOLERANCE, {15'($urandom), 17'($urandom_range(0, 40000))});
        set_register(CFG_BETA, {15'($urandom), 17'($urandom_range(0, 65536))});
        set_register(CFG_MIN_GUARD,
                     ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 20000)));
        test_random_traffic(count);
    endtask

    initial
    begin
        #200_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        idling_on     = 1'b1;
        clock_us      = '0;
        events_sent   = 0;
        settings_used = 0;

        cfg_copy.init_window    = RST_INITIAL_WINDOW;
        cfg_copy.init_threshold = RST_INITIAL_THRESHOLD;
        cfg_copy.max_window     = RST_MAX_WINDOW;
        cfg_copy.min_window     = RST_MIN_WINDOW;
        cfg_copy.alpha          = RST_LOSS_ALPHA;
        cfg_copy.tolerance      = RST_LOSS_TOLERANCE;
        cfg_copy.beta           = RST_BETA;
        cfg_copy.min_guard      = RST_MIN_GUARD;
        restart_window_model();

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_event_kinds();
        test_cut_coalescing();
        test_random_traffic(300);
        test_flight_saturation();
        test_register_extremes();
        repeat (5) test_random_settings(170);

        wait_drained();
        $display("Checked %0d results from %0d events, %0d of them window cuts.",
                 reports_checked, events_sent, cuts_observed);
        $display("Traffic ran under %0d register settings, the extremes included.",
                 settings_used);
        if (error_count == 0 && pending_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
hw/rtl/acw_pkg.sv
hw/rtl/acw_divider.sv
hw/rtl/acw_engine.sv
hw/rtl/aimd_congestion_window.sv
hw/rtl/acw_checker.sv
dv/tb_aimd_congestion_window.sv
